@@ rtl/mnht_pkg.sv @@
// ----------------------------------------------------------------------------
// mnht_pkg
// Shared types, constants and helpers for the note hold tracker.
// ----------------------------------------------------------------------------
package mnht_pkg;

  localparam int NOTE_COUNT    = 128;
  localparam int CHANNEL_COUNT = 16;
  localparam int TABLE_SIZE    = NOTE_COUNT * CHANNEL_COUNT;
  localparam int IDX_W         = $clog2(TABLE_SIZE);
  localparam int CNT_W         = IDX_W + 1;
  localparam int HOLD_W        = 8;

  localparam logic [7:0]        TYPE_MASK     = 8'hF0;
  localparam logic [7:0]        CHAN_MASK     = 8'h0F;
  localparam logic [7:0]        TYPE_NOTE_ON  = 8'h90;
  localparam logic [7:0]        TYPE_NOTE_OFF = 8'h80;
  localparam logic [HOLD_W-1:0] HOLD_MAX      = 8'd255;

  localparam logic [1:0] REQ_MSG   = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [HOLD_W-1:0] hold;
    logic              flag;
  } entry_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_ON,
    OP_OFF,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MSG_RD,
    ST_MSG_WR,
    ST_TICK,
    ST_QRY_RD,
    ST_QRY_OUT
  } state_t;

  function automatic idx_t entry_idx(input logic [7:0] note, input logic [3:0] chan);
    int sum;
    sum = int'(note) * CHANNEL_COUNT + int'(chan);
    return IDX_W'(sum);
  endfunction

endpackage

@@ rtl/mnht_mem.sv @@
// ----------------------------------------------------------------------------
// mnht_mem
// Key-state table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mnht_mem
  import mnht_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t mem [TABLE_SIZE];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/mnht_alu.sv @@
// ----------------------------------------------------------------------------
// mnht_alu
// Shared entry update unit used by the tick sweep, messages and clearing.
// ----------------------------------------------------------------------------
module mnht_alu
  import mnht_pkg::*;
(
  input  op_t    op,
  input  entry_t old_entry,
  output entry_t new_entry
);

  always_comb begin
    new_entry = old_entry;
    unique case (op)
      OP_TICK: begin
        new_entry.flag = 1'b0;
        if (old_entry.hold != '0 && old_entry.hold != HOLD_MAX) begin
          new_entry.hold = old_entry.hold + HOLD_W'(1);
        end
      end
      OP_ON: begin
        new_entry.hold = HOLD_W'(1);
        new_entry.flag = 1'b1;
      end
      // note-off keeps the flag
      OP_OFF: begin
        new_entry.hold = '0;
      end
      OP_CLEAR: begin
        new_entry = '0;
      end
      default: begin
        new_entry = old_entry;
      end
    endcase
  end

endmodule

@@ rtl/midi_note_hold_tracker_core.sv @@
// ----------------------------------------------------------------------------
// midi_note_hold_tracker_core
// Per note and channel hold-frame counter and just-pressed flag table.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 2048-entry table to zero, one entry a
// cycle, and takes no item until the sweep ends. A MIDI message steps
// through accept, table read and write back; a query through accept, table
// read and any wait for the result register to drain. A frame tick walks
// the whole table through the memory's read and write ports and the shared
// update unit, one entry a cycle, until the sweep ends. One item is in work
// at a time; the result register lets a finished query wait downstream.
module midi_note_hold_tracker_core
  import mnht_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // midi_word[23:0], query_note[31:24], query_channel[35:32]
  input  logic [1:0]  in_tuser,  // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata  // hold_frames[7:0], just_pressed[8]
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  idx_t               idx_r, idx_nxt;
  op_t                op_r, op_nxt;
  logic               qzero_r, qzero_nxt;
  logic               out_valid_r, out_valid_nxt;
  entry_t             out_data_r, out_data_nxt;

  mem_req_t           mem_req;
  entry_t             rd_data;
  op_t                alu_op;
  entry_t             alu_out;

  logic [23:0]        midi_word;
  logic [7:0]         query_note;
  logic [3:0]         query_channel;
  logic [7:0]         status_b, note_b, vel_b;
  logic               accept;
  logic               note_ok, chan_ok, is_on, is_off;

  assign midi_word     = in_tdata[23:0];
  assign query_note    = in_tdata[31:24];
  assign query_channel = in_tdata[35:32];
  assign status_b      = midi_word[7:0];
  assign note_b        = midi_word[15:8];
  assign vel_b         = midi_word[23:16];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign note_ok = int'(note_b) < NOTE_COUNT;
  assign chan_ok = int'(status_b & CHAN_MASK) < CHANNEL_COUNT;
  assign is_on   = ((status_b & TYPE_MASK) == TYPE_NOTE_ON) && (vel_b != 8'd0);
  assign is_off  = ((status_b & TYPE_MASK) == TYPE_NOTE_OFF) ||
                   (((status_b & TYPE_MASK) == TYPE_NOTE_ON) && (vel_b == 8'd0));

  // op_r already holds the tick op during a sweep
  assign alu_op = (state_r == ST_CLEAR) ? OP_CLEAR : op_r;

  mnht_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  mnht_alu u_alu (
    .op        (alu_op),
    .old_entry (rd_data),
    .new_entry (alu_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    op_r       <= op_nxt;
    qzero_r    <= qzero_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    qzero_nxt     = qzero_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_req       = '{we: 1'b0, waddr: idx_r, wdata: alu_out, raddr: idx_r};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r[IDX_W-1:0];
        if (int'(cnt_r) == TABLE_SIZE - 1) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          priority if (in_tuser == REQ_MSG) begin
            idx_nxt = entry_idx(note_b, status_b[3:0]);
            op_nxt  = is_on ? OP_ON : OP_OFF;
            if (note_ok && chan_ok && (is_on || is_off)) begin
              state_nxt = ST_MSG_RD;
            end
          end else if (in_tuser == REQ_TICK) begin
            cnt_nxt   = '0;
            op_nxt    = OP_TICK;
            state_nxt = ST_TICK;
          end else if (in_tuser == REQ_QUERY) begin
            idx_nxt   = entry_idx(query_note, query_channel);
            qzero_nxt = !((int'(query_note) < NOTE_COUNT) &&
                          (int'(query_channel) < CHANNEL_COUNT));
            state_nxt = ST_QRY_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MSG_RD: begin
        state_nxt = ST_MSG_WR;
      end
      ST_MSG_WR: begin
        mem_req.we = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_TICK: begin
        // read entry cnt, write back entry cnt-1 from the registered read data
        mem_req.raddr = cnt_r[IDX_W-1:0];
        mem_req.waddr = IDX_W'(cnt_r - CNT_W'(1));
        mem_req.we    = (cnt_r != '0);
        if (int'(cnt_r) == TABLE_SIZE) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_QRY_RD: begin
        state_nxt = ST_QRY_OUT;
      end
      ST_QRY_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = qzero_r ? '0 : rd_data;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r.flag, out_data_r.hold};

  a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_QRY_OUT)
    else $error("result raised outside query completion");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_QRY_RD || state_r == ST_QRY_OUT) |-> !mem_req.we)
    else $error("table written while no update in progress");

  a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TICK |-> int'(cnt_r) <= TABLE_SIZE)
    else $error("tick sweep counter past table end");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> state_r == ST_CLEAR)
    else $error("table clear skipped after reset");

  a_msg_writes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MSG_RD |=> state_r == ST_MSG_WR && mem_req.we)
    else $error("message read not followed by write back");

endmodule
